### rtl/afp_pkg.sv
// Types, constants and step functions shared by the affine frame point pipeline.
`default_nettype none

package afp_pkg;

   localparam int REQ_W = 128;
   localparam int RSP_W = 184;

   // Pipeline layout.
   localparam int CORDIC_STEPS  = 16;
   localparam int CORDIC_PER    = 4;
   localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;
   localparam int SQRT_STEPS    = 30;
   localparam int SQRT_PER      = 2;
   localparam int SQRT_STAGES   = SQRT_STEPS / SQRT_PER;
   localparam int QUO_BITS      = 20;
   localparam int DIV_PER       = 2;
   localparam int DIV_STAGES    = QUO_BITS / DIV_PER;

   localparam int ST_IN      = 0;
   localparam int ST_CORDIC0 = ST_IN + 1;
   localparam int ST_P1      = ST_CORDIC0 + CORDIC_STAGES;
   localparam int ST_P2      = ST_P1 + 1;
   localparam int ST_P3      = ST_P2 + 1;
   localparam int ST_SQRT0   = ST_P3 + 1;
   localparam int ST_M1      = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_M2      = ST_M1 + 1;
   localparam int ST_DIV0    = ST_M2 + 1;
   localparam int ST_OUT     = ST_DIV0 + DIV_STAGES;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic signed [19:0] ANG_PI      = 20'sd205888;
   localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
   localparam logic signed [16:0] CORDIC_X0   = 17'sd16384;

   localparam logic signed [19:0] ATAN_Q16 [0:CORDIC_STEPS-1] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
      20'sd8, 20'sd4, 20'sd2
   };

   localparam logic signed [21:0] PT_MAX = 22'sd131071;
   localparam logic signed [21:0] PT_MIN = -22'sd131072;
   localparam logic [19:0]        QUO_SAT = 20'h80000;

   typedef struct packed {
      logic [59:0] val;
      logic [31:0] rem;
      logic [29:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [47:0] rem;
      logic [19:0] quo;
   } div_type;

   typedef struct packed {
      logic [15:0]          mx;
      logic [15:0]          my;
      logic [24:0]          a;
      logic [24:0]          c;
      logic signed [25:0]   b;
      logic signed [16:0]   x;
      logic signed [16:0]   y;
      logic signed [19:0]   z;
      logic                 flip;
      logic [49:0]          ac;
      logic [50:0]          bb;
      logic signed [51:0]   det;
      logic signed [16:0]   ci;
      logic signed [16:0]   si;
      logic [29:0]          ss;
      logic [29:0]          cc;
      logic signed [30:0]   sc;
      logic signed [42:0]   bci;
      logic signed [42:0]   asi;
      logic signed [42:0]   cci;
      logic signed [42:0]   bsi;
      logic [54:0]          a_ss;
      logic [54:0]          c_cc;
      logic signed [56:0]   b_sc;
      logic signed [43:0]   n2x;
      logic signed [43:0]   n2y;
      logic                 degen;
      sqrt_type             rq;
      sqrt_type             rd;
      logic [28:0]          sq;
      logic signed [42:0]   p1x;
      logic signed [42:0]   p1y;
      div_type [3:0]        dv;
      logic [3:0]           neg;
      logic [9:0][17:0]     pts;
   } item_type;

   // One bit of a digit-by-digit square root.
   function automatic sqrt_type sqrt_step(sqrt_type s);
      logic [33:0] r2;
      logic [33:0] t;
      sqrt_type    o;
      r2    = {s.rem, s.val[59:58]};
      t     = {2'b00, s.root, 2'b01};
      o.val = {s.val[57:0], 2'b00};
      if (r2 >= t) begin
         o.rem  = 32'(r2 - t);
         o.root = {s.root[28:0], 1'b1};
      end else begin
         o.rem  = r2[31:0];
         o.root = {s.root[28:0], 1'b0};
      end
      return o;
   endfunction

   // One quotient bit of a restoring division.
   function automatic div_type div_step(div_type d, logic [28:0] den, logic [4:0] bpos);
      logic [47:0] sh;
      div_type     o;
      sh = {19'b0, den} << bpos;
      o  = d;
      if (d.rem >= sh) begin
         o.rem       = d.rem - sh;
         o.quo[bpos] = 1'b1;
      end
      return o;
   endfunction

   function automatic logic [17:0] sat18(logic signed [21:0] v);
      logic [17:0] r;
      if (v > PT_MAX) begin
         r = PT_MAX[17:0];
      end else if (v < PT_MIN) begin
         r = PT_MIN[17:0];
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/affine_frame_points.sv
// Pipelined affine frame point generator: five stabilization points per region.
//
//  Channel  | Direction | Contents
//  req_     | in        | tdata: mean_x, mean_y, var_x, covar_xy, var_y, orient_angle
//  rsp_     | out       | tdata: ten 18-bit point coordinates; tuser: degenerate
//
// A request can enter every cycle unless a result waits at the output.
// The depth is set by the 30-step square root and the 20-step divider,
// two steps per stage, behind a four-stage CORDIC and three multiply stages.
// Reset is synchronous and clears only the stage valid bits.
// When a result waits at the output, the whole pipeline holds in place.
`default_nettype none

module affine_frame_points (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mean_x[15:0], mean_y[31:16], var_x[56:32], covar_xy[82:57],
   // var_y[107:83], orient_angle[123:108]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // center_x, center_y, plus_first_x, plus_first_y, plus_second_x,
   // plus_second_y, minus_first_x, minus_first_y, minus_second_x,
   // minus_second_y, 18 bits each from bit 0 up
   output logic [183:0]      rsp_tdata,
   // degenerate
   output logic [0:0]        rsp_tuser
);

   localparam int LAST = afp_pkg::NUM_STAGES - 1;

   afp_pkg::item_type pipe_ff [afp_pkg::NUM_STAGES];
   afp_pkg::item_type pipe_in [afp_pkg::NUM_STAGES];
   logic [afp_pkg::NUM_STAGES-1:0] vld_ff;
   logic                           adv;

   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = {4'b0000, pipe_ff[LAST].pts};
   assign rsp_tuser  = pipe_ff[LAST].degen;

   // Input stage: unpack and fold the angle into [-pi/2, pi/2].
   always_comb begin
      afp_pkg::item_type nx;
      logic signed [19:0] z0;
      nx    = '0;
      nx.mx = req_tdata[15:0];
      nx.my = req_tdata[31:16];
      nx.a  = req_tdata[56:32];
      nx.b  = $signed(req_tdata[82:57]);
      nx.c  = req_tdata[107:83];
      z0    = $signed({req_tdata[123], req_tdata[123:108], 3'b000});
      nx.x  = afp_pkg::CORDIC_X0;
      nx.y  = '0;
      if (z0 > afp_pkg::ANG_HALF_PI) begin
         nx.z    = z0 - afp_pkg::ANG_PI;
         nx.flip = 1'b1;
      end else if (z0 < -afp_pkg::ANG_HALF_PI) begin
         nx.z    = z0 + afp_pkg::ANG_PI;
         nx.flip = 1'b1;
      end else begin
         nx.z    = z0;
         nx.flip = 1'b0;
      end
      pipe_in[afp_pkg::ST_IN] = nx;
   end

   for (genvar g = 1; g < afp_pkg::NUM_STAGES; g++) begin : g_stage
      if (g < afp_pkg::ST_P1) begin : g_cordic
         localparam int K = g - afp_pkg::ST_CORDIC0;
         always_comb begin
            afp_pkg::item_type  nx;
            logic signed [16:0] xs;
            logic signed [16:0] ys;
            logic [3:0]         idx;
            nx = pipe_ff[g-1];
            for (int j = 0; j < afp_pkg::CORDIC_PER; j++) begin
               idx = 4'(K * afp_pkg::CORDIC_PER + j);
               xs  = nx.x >>> idx;
               ys  = nx.y >>> idx;
               if (!nx.z[19]) begin
                  nx.x = nx.x - ys;
                  nx.y = nx.y + xs;
                  nx.z = nx.z - afp_pkg::ATAN_Q16[idx];
               end else begin
                  nx.x = nx.x + ys;
                  nx.y = nx.y - xs;
                  nx.z = nx.z + afp_pkg::ATAN_Q16[idx];
               end
            end
            // The determinant is formed alongside the rotation.
            if (K == 0) begin
               nx.ac = nx.a * nx.c;
               nx.bb = 51'(nx.b * nx.b);
            end
            if (K == 1) begin
               nx.det = $signed({2'b00, nx.ac}) - $signed({1'b0, nx.bb});
            end
            pipe_in[g] = nx;
         end
      end else if (g == afp_pkg::ST_P1) begin : g_p1
         always_comb begin
            afp_pkg::item_type  nx;
            logic signed [16:0] cv;
            logic signed [16:0] sv;
            nx    = pipe_ff[g-1];
            cv    = nx.flip ? -nx.x : nx.x;
            sv    = nx.flip ? -nx.y : nx.y;
            nx.ci = cv;
            nx.si = sv;
            nx.ss = 30'(sv * sv);
            nx.cc = 30'(cv * cv);
            nx.sc = 31'(sv * cv);
            nx.bci = 43'(nx.b * cv);
            nx.bsi = 43'(nx.b * sv);
            nx.asi = 43'($signed({1'b0, nx.a}) * sv);
            nx.cci = 43'($signed({1'b0, nx.c}) * cv);
            pipe_in[g] = nx;
         end
      end else if (g == afp_pkg::ST_P2) begin : g_p2
         always_comb begin
            afp_pkg::item_type nx;
            nx      = pipe_ff[g-1];
            nx.a_ss = nx.a * nx.ss;
            nx.c_cc = nx.c * nx.cc;
            nx.b_sc = 57'(nx.b * nx.sc);
            nx.n2x  = 44'(nx.bci) - 44'(nx.asi);
            nx.n2y  = 44'(nx.cci) - 44'(nx.bsi);
            pipe_in[g] = nx;
         end
      end else if (g == afp_pkg::ST_P3) begin : g_p3
         always_comb begin
            afp_pkg::item_type  nx;
            logic signed [58:0] qi;
            nx = pipe_ff[g-1];
            qi = $signed({4'b0000, nx.a_ss}) - $signed({nx.b_sc[56], nx.b_sc, 1'b0})
               + $signed({4'b0000, nx.c_cc});
            nx.degen = (nx.a == '0) || nx.det[51] || (nx.det == '0) || qi[58] || (qi == '0);
            nx.rq = '0;
            nx.rd = '0;
            if (!nx.degen) begin
               nx.rq.val = {1'b0, qi};
               nx.rd.val = {8'h00, nx.det};
            end
            pipe_in[g] = nx;
         end
      end else if (g < afp_pkg::ST_M1) begin : g_sqrt
         always_comb begin
            afp_pkg::item_type nx;
            nx = pipe_ff[g-1];
            for (int j = 0; j < afp_pkg::SQRT_PER; j++) begin
               nx.rq = afp_pkg::sqrt_step(nx.rq);
               nx.rd = afp_pkg::sqrt_step(nx.rd);
            end
            pipe_in[g] = nx;
         end
      end else if (g == afp_pkg::ST_M1) begin : g_m1
         always_comb begin
            afp_pkg::item_type nx;
            nx       = pipe_ff[g-1];
            nx.sq    = nx.rq.root[28:0];
            nx.degen = nx.degen || (nx.rq.root[28:0] == '0);
            nx.p1x   = 43'($signed({1'b0, nx.rd.root[24:0]}) * nx.ci);
            nx.p1y   = 43'($signed({1'b0, nx.rd.root[24:0]}) * nx.si);
            pipe_in[g] = nx;
         end
      end else if (g == afp_pkg::ST_M2) begin : g_m2
         always_comb begin
            afp_pkg::item_type        nx;
            logic signed [3:0][45:0]  num;
            logic [45:0]              mag;
            nx     = pipe_ff[g-1];
            num[0] = {{1{nx.p1x[42]}}, nx.p1x, 2'b00};
            num[1] = {{1{nx.p1y[42]}}, nx.p1y, 2'b00};
            num[2] = {nx.n2x, 2'b00};
            num[3] = {nx.n2y, 2'b00};
            for (int m = 0; m < 4; m++) begin
               nx.neg[m]    = num[m][45];
               mag          = num[m][45] ? 46'(-num[m]) : num[m];
               // Adding half the divisor rounds to nearest, ties away from zero.
               nx.dv[m].rem = {2'b00, mag} + {20'b0, nx.sq[28:1]};
               nx.dv[m].quo = '0;
            end
            pipe_in[g] = nx;
         end
      end else if (g < afp_pkg::ST_OUT) begin : g_div
         localparam int K = g - afp_pkg::ST_DIV0;
         always_comb begin
            afp_pkg::item_type nx;
            nx = pipe_ff[g-1];
            for (int j = 0; j < afp_pkg::DIV_PER; j++) begin
               for (int m = 0; m < 4; m++) begin
                  nx.dv[m] = afp_pkg::div_step(nx.dv[m], nx.sq,
                     5'(afp_pkg::QUO_BITS - 1 - K * afp_pkg::DIV_PER - j));
               end
            end
            pipe_in[g] = nx;
         end
      end else begin : g_out
         always_comb begin
            afp_pkg::item_type        nx;
            logic [19:0]              mag;
            logic signed [3:0][21:0]  dsig;
            logic signed [21:0]       cx;
            logic signed [21:0]       cy;
            nx = pipe_ff[g-1];
            for (int m = 0; m < 4; m++) begin
               // The top quotient bit flags a quotient too large for any point.
               mag     = nx.dv[m].quo[19] ? afp_pkg::QUO_SAT : nx.dv[m].quo;
               dsig[m] = nx.neg[m] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
               if (nx.degen) begin
                  dsig[m] = '0;
               end
            end
            cx        = $signed({6'b0, nx.mx});
            cy        = $signed({6'b0, nx.my});
            nx.pts[0] = afp_pkg::sat18(cx);
            nx.pts[1] = afp_pkg::sat18(cy);
            nx.pts[2] = afp_pkg::sat18(cx + dsig[0]);
            nx.pts[3] = afp_pkg::sat18(cy + dsig[1]);
            nx.pts[4] = afp_pkg::sat18(cx + dsig[2]);
            nx.pts[5] = afp_pkg::sat18(cy + dsig[3]);
            nx.pts[6] = afp_pkg::sat18(cx - dsig[0]);
            nx.pts[7] = afp_pkg::sat18(cy - dsig[1]);
            nx.pts[8] = afp_pkg::sat18(cx - dsig[2]);
            nx.pts[9] = afp_pkg::sat18(cy - dsig[3]);
            pipe_in[g] = nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[afp_pkg::NUM_STAGES-2:0], req_tvalid};
      end
   end

   // A degenerate region puts every point on the mean.
   a_degen_on_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         pipe_ff[LAST].pts[2] == pipe_ff[LAST].pts[0] &&
         pipe_ff[LAST].pts[6] == pipe_ff[LAST].pts[0] &&
         pipe_ff[LAST].pts[5] == pipe_ff[LAST].pts[1] &&
         pipe_ff[LAST].pts[9] == pipe_ff[LAST].pts[1])
      else $error("degenerate result with points off the mean");

   // A held output freezes every stage.
   a_hold_all: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while the output was held");

   // Past the roots, a live region always has a nonzero divisor.
   a_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[afp_pkg::ST_M1] && !pipe_ff[afp_pkg::ST_M1].degen |->
         pipe_ff[afp_pkg::ST_M1].sq != '0)
      else $error("zero divisor on a live region");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");

endmodule

`default_nettype wire

### tb/sv/affine_frame_points_tb.sv
// Self-checking bench for the affine frame point pipeline with random stimulus and stalls.
`default_nettype none

module affine_frame_points_tb;

   typedef struct {
      logic [17:0] pt [0:9];
      logic        degen;
   } frame_points_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   bit              sending_done;
   int              hold_cycles;
   int              idle_cycles;
   int              rsp_wait;
   int              wait_draw;

   affine_frame_points i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint floor_div2k(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint round_quotient(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic [17:0] clamp_point(longint v);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
   endfunction

   function automatic frame_points_type predict_points(logic [127:0] d);
      longint           mx, my, a, b, c, ang, det, qi, sq, sd, z, x, y, xs, ys;
      longint           d1x, d1y, d2x, d2y;
      bit               flip;
      frame_points_type fp;
      mx  = d[15:0];
      my  = d[31:16];
      a   = d[56:32];
      b   = longint'($signed(d[82:57]));
      c   = d[107:83];
      ang = longint'($signed(d[123:108]));
      det = a * c - b * b;
      d1x = 0; d1y = 0; d2x = 0; d2y = 0;
      fp.degen = 1'b1;
      if (a > 0 && det > 0) begin
         z = ang * 8;
         flip = 0;
         if (z > afp_pkg::ANG_HALF_PI) begin
            z = z - afp_pkg::ANG_PI;
            flip = 1;
         end else if (z < -afp_pkg::ANG_HALF_PI) begin
            z = z + afp_pkg::ANG_PI;
            flip = 1;
         end
         x = 16384;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            xs = floor_div2k(x, i);
            ys = floor_div2k(y, i);
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - afp_pkg::ATAN_Q16[i];
            end else begin
               x = x + ys; y = y - xs; z = z + afp_pkg::ATAN_Q16[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         qi = a * y * y - 2 * b * y * x + c * x * x;
         if (qi > 0) begin
            sq = int_sqrt(qi);
            if (sq > 0) begin
               sd = int_sqrt(det);
               d1x = round_quotient(4 * sd * x, sq);
               d1y = round_quotient(4 * sd * y, sq);
               d2x = round_quotient(4 * (b * x - a * y), sq);
               d2y = round_quotient(4 * (c * x - b * y), sq);
               fp.degen = 1'b0;
            end
         end
      end
      fp.pt[0] = clamp_point(mx);       fp.pt[1] = clamp_point(my);
      fp.pt[2] = clamp_point(mx + d1x); fp.pt[3] = clamp_point(my + d1y);
      fp.pt[4] = clamp_point(mx + d2x); fp.pt[5] = clamp_point(my + d2y);
      fp.pt[6] = clamp_point(mx - d1x); fp.pt[7] = clamp_point(my - d1y);
      fp.pt[8] = clamp_point(mx - d2x); fp.pt[9] = clamp_point(my - d2y);
      return fp;
   endfunction

   // Holds the predicted frame points of every accepted request, oldest first.
   class frame_scoreboard;
      frame_points_type pending [$];
      int               errors;

      function void note_request(logic [127:0] data);
         frame_points_type fp;
         fp = predict_points(data);
         pending.insert(pending.size(), fp);
      endfunction

      function void check_result(logic [183:0] data, logic degen);
         frame_points_type fp;
         string            names [0:9];
         names = '{"center_x", "center_y", "plus_first_x", "plus_first_y",
                   "plus_second_x", "plus_second_y", "minus_first_x",
                   "minus_first_y", "minus_second_x", "minus_second_y"};
         if (pending.size() == 0) begin
            $error("unexpected result %h", data);
            errors++;
            return;
         end
         fp = pending.pop_front();
         for (int i = 0; i < 10; i++) begin
            if (data[i*18 +: 18] !== fp.pt[i]) begin
               $error("%s expected %0d actual %0d", names[i],
                      $signed(fp.pt[i]), $signed(data[i*18 +: 18]));
               errors++;
            end
         end
         if (degen !== fp.degen) begin
            $error("degenerate expected %0d actual %0d", fp.degen, degen);
            errors++;
         end
      endfunction
   endclass

   frame_scoreboard board;

   function automatic logic [127:0] pack_region(logic [15:0] mx, logic [15:0] my,
         logic [24:0] a, logic [25:0] b, logic [24:0] c, logic [15:0] ang);
      return {4'b0, ang, c, b, a, my, mx};
   endfunction

   // Mostly well-conditioned regions; the rest are raw random fields.
   function automatic logic [127:0] random_region();
      logic [24:0] a, c;
      logic [25:0] b;
      longint      lim;
      int          shift;
      logic [15:0] ang;
      ang = 16'($urandom_range(0, 51472) - 25736);
      if ($urandom_range(0, 9) == 0) begin
         ang = 16'($urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
         a = 25'($urandom);
         b = 26'($urandom);
         c = 25'($urandom);
      end else begin
         shift = $urandom_range(0, 24);
         a = 25'($urandom) >> shift;
         c = 25'($urandom) >> $urandom_range(0, 24);
         lim = int_sqrt(longint'(a) * longint'(c));
         b = 26'($urandom_range(0, 32'(lim)));
         if ($urandom_range(0, 1)) b = -b;
      end
      return pack_region(16'($urandom), 16'($urandom), a, b, c, ang);
   endfunction

   task automatic send_region(logic [127:0] data);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(data);
   endtask

   initial begin
      board = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      hold_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: field extremes, degenerate covariances, angle folding.
      send_region(pack_region(16'h0000, 16'h0000, 25'd0, 26'd0, 25'd0, 16'd0));
      send_region(pack_region(16'hFFFF, 16'hFFFF, 25'h1FFFFFF, 26'd0,
                              25'h1FFFFFF, 16'd0));
      send_region(pack_region(16'd100, 16'd200, 25'd64, 26'd64, 25'd64, 16'd0));
      send_region(pack_region(16'd100, 16'd200, 25'd64, -26'sd100, 25'd64, 16'd0));
      send_region(pack_region(16'd0, 16'd0, 25'd0, 26'd0, 25'd50, 16'd100));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd0, 25'd256, 16'd25736));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd0, 25'd256,
                              -16'sd25736));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd0, 25'd256, 16'h7FFF));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd0, 25'd256, 16'h8000));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd10, 25'd300, 16'd12868));
      send_region(pack_region(16'd500, 16'd500, 25'd256, 26'd10, 25'd300,
                              -16'sd12868));
      send_region(pack_region(16'd10, 16'hFFF0, 25'h1FFFFFF, 26'h1FFFFFF,
                              25'h1FFFFFF, 16'd6000));
      send_region(pack_region(16'd10, 16'hFFF0, 25'h1FFFFFF, 26'h2000000,
                              25'h1FFFFFF, 16'd6000));
      send_region(pack_region(16'd10, 16'd10, 25'd1, 26'd0, 25'd1, 16'd0));
      send_region(pack_region(16'd0, 16'd0, 25'h1FFFFFF, 26'd0, 25'd1, 16'd3000));
      send_region(pack_region(16'hFFFF, 16'd0, 25'd1, 26'd0, 25'h1FFFFFF, 16'd9000));
      for (int n = 0; n < 1040; n++) begin
         // Long output stall while requests keep coming, to fill the pipeline.
         if (n == 300) hold_cycles = 600;
         send_region(random_region());
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata, rsp_tuser[0]);
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready  <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            wait_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            rsp_wait   <= wait_draw;
            rsp_tready <= (wait_draw == 0);
         end else if (!rsp_tready) begin
            if (rsp_wait > 1) begin
               rsp_wait <= rsp_wait - 1;
            end else begin
               rsp_wait   <= 0;
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      sending_done = 1'b0;
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles > 2000) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (sending_done && board.pending.size() == 0) begin
            repeat (60) @(posedge clock);
            if (board.errors == 0 && board.pending.size() == 0 && !rsp_tvalid) begin
               $display("RESULT: OK");
            end else begin
               $display("RESULT: ERROR");
            end
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
